### rtl/ctc_pkg.sv
// calendar tick counter: shared types, constants and helper functions
// no dependencies; imported by ctc_next_time, calendar_tick_counter and the bench
`timescale 1ns / 1ps

package ctc_pkg;

    // request kinds carried in the input tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam int unsigned LOAD_BYTES = 6;
    localparam int unsigned LOAD_W     = 8 * LOAD_BYTES;

    localparam logic [7:0] SEC_LAST   = 8'd59;
    localparam logic [7:0] MIN_LAST   = 8'd59;
    localparam logic [7:0] HOUR_LAST  = 8'd23;
    localparam logic [7:0] MONTH_LAST = 8'd12;
    localparam logic [7:0] YEAR_LAST  = 8'd99;

    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [3:0] MONTH_FIRST = 4'd1;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } cal_time_t;

    localparam int unsigned TIME_W = $bits(cal_time_t);

    // days in month m; leap february when the two low year bits are zero
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [1:0] y_lo);
        logic [4:0] len;
        begin
            unique case (m)
                4'd2:    len = (y_lo == 2'd0) ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // bcd nibbles above nine decode arithmetically as well
    function automatic logic [7:0] byte_decode(input logic [7:0] b, input logic bin);
        logic [7:0] bcd;
        begin
            bcd = 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
            return bin ? b : bcd;
        end
    endfunction

endpackage

### rtl/ctc_next_time.sv
// calendar tick counter: next time from a one-second tick or a checked load
// depends on ctc_pkg
`timescale 1ns / 1ps

module ctc_next_time (
    input  ctc_pkg::cal_time_t            cur,
    input  logic                          req_type,
    input  logic [ctc_pkg::LOAD_W-1:0]    load_bytes,
    input  logic                          binary_mode,
    output ctc_pkg::cal_time_t            nxt,
    output logic                          rejected
);
    import ctc_pkg::*;

    cal_time_t  ticked;
    cal_time_t  loaded;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;
    logic [7:0] s_dec;
    logic [7:0] mi_dec;
    logic [7:0] h_dec;
    logic [7:0] d_dec;
    logic [7:0] mo_dec;
    logic [7:0] y_dec;
    logic       load_ok;

    // tick carry chain
    always_comb
    begin
        sec_wrap   = ({2'd0, cur.sec} == SEC_LAST);
        min_wrap   = sec_wrap && ({2'd0, cur.min} == MIN_LAST);
        hour_wrap  = min_wrap && ({3'd0, cur.hour} == HOUR_LAST);
        day_wrap   = hour_wrap && (cur.day >= month_days(cur.month, cur.year[1:0]));
        month_wrap = day_wrap && ({4'd0, cur.month} >= MONTH_LAST);

        ticked       = cur;
        ticked.sec   = sec_wrap ? 6'd0 : cur.sec + 6'd1;
        if (sec_wrap)
        begin
            ticked.min = min_wrap ? 6'd0 : cur.min + 6'd1;
        end
        if (min_wrap)
        begin
            ticked.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
        end
        if (hour_wrap)
        begin
            ticked.day = day_wrap ? DAY_FIRST : cur.day + 5'd1;
        end
        if (day_wrap)
        begin
            ticked.month = month_wrap ? MONTH_FIRST : cur.month + 4'd1;
        end
        if (month_wrap)
        begin
            ticked.year = ({1'b0, cur.year} >= YEAR_LAST) ? 7'd0 : cur.year + 7'd1;
        end
    end

    // load decode and range check
    always_comb
    begin
        s_dec  = byte_decode(load_bytes[7:0],   binary_mode);
        mi_dec = byte_decode(load_bytes[15:8],  binary_mode);
        h_dec  = byte_decode(load_bytes[23:16], binary_mode);
        d_dec  = byte_decode(load_bytes[31:24], binary_mode);
        mo_dec = byte_decode(load_bytes[39:32], binary_mode);
        y_dec  = byte_decode(load_bytes[47:40], binary_mode);

        load_ok = (s_dec <= SEC_LAST) && (mi_dec <= MIN_LAST) && (h_dec <= HOUR_LAST)
               && (y_dec <= YEAR_LAST) && (mo_dec != 8'd0) && (mo_dec <= MONTH_LAST)
               && (d_dec != 8'd0)
               && (d_dec <= {3'd0, month_days(mo_dec[3:0], y_dec[1:0])});

        loaded.sec   = s_dec[5:0];
        loaded.min   = mi_dec[5:0];
        loaded.hour  = h_dec[4:0];
        loaded.day   = d_dec[4:0];
        loaded.month = mo_dec[3:0];
        loaded.year  = y_dec[6:0];
    end

    always_comb
    begin
        unique case (req_type)
            REQ_LOAD:
            begin
                nxt      = load_ok ? loaded : cur;
                rejected = !load_ok;
            end
            default:
            begin
                nxt      = ticked;
                rejected = 1'b0;
            end
        endcase
    end

endmodule

### rtl/calendar_tick_counter.sv
// calendar tick counter top level: input register, time state, result register
// depends on ctc_pkg and ctc_next_time
`timescale 1ns / 1ps

// channel    direction  tdata                                      tuser
// s_axis     in         load sec, min, hour, day, month, year     req_type
//                       (8 bits each)
// m_axis     out        sec 6, min 6, hour 5, day 5, month 4,     load_rejected
//                       year 7, zero pad 7
// cfg        in         binary_mode on cfg_wr_data when cfg_wr_en  -
//
// one transfer per cycle sustained while m_axis does not stall; a result becomes
// valid and can transfer only after its input has passed the input register
// and then the state and result register
// reset gives 00:00:00, day 1, month 1, year 0, bcd mode
// a stall on m_axis holds the result register and backs up into the input
// register; s_axis_tready drops only when both are full

module calendar_tick_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ctc_pkg::LOAD_W-1:0]    s_axis_tdata,  // sec, min, hour, day, month, year
    input  logic                          s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // sec, min, hour, day, month, year
    output logic                          m_axis_tuser   // load_rejected
);
    import ctc_pkg::*;

    logic              binary_mode_reg;
    logic              in_valid_reg;
    logic              in_type_reg;
    logic [LOAD_W-1:0] in_data_reg;
    cal_time_t         time_reg;
    cal_time_t         time_next;
    logic              out_valid_reg;
    logic              out_rej_reg;
    logic              rej_next;
    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    ctc_next_time u_next (
        .cur         (time_reg),
        .req_type    (in_type_reg),
        .load_bytes  (in_data_reg),
        .binary_mode (binary_mode_reg),
        .nxt         (time_next),
        .rejected    (rej_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            binary_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_type_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '{year: 7'd0, month: MONTH_FIRST, day: DAY_FIRST,
                               hour: 5'd0, min: 6'd0, sec: 6'd0};
            out_valid_reg <= 1'b0;
            out_rej_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                time_reg      <= time_next;
                out_rej_reg   <= rej_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(40 - TIME_W)'(0), time_reg};
    assign m_axis_tuser  = out_rej_reg;

    // time state always holds a legal calendar value
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ({2'd0, time_reg.sec} <= SEC_LAST) && ({2'd0, time_reg.min} <= MIN_LAST)
        && ({3'd0, time_reg.hour} <= HOUR_LAST) && ({1'b0, time_reg.year} <= YEAR_LAST)
        && (time_reg.month != 4'd0) && ({4'd0, time_reg.month} <= MONTH_LAST)
        && (time_reg.day != 5'd0)
        && (time_reg.day <= month_days(time_reg.month, time_reg.year[1:0])))
        else $error("time state out of range");

    // a refused load leaves the time untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && rej_next) |=> (time_reg == $past(time_reg)))
        else $error("rejected load changed the time");

    // a tick is never flagged as rejected
    a_tick_no_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_type_reg == REQ_TICK)) |=> (m_axis_tvalid && !m_axis_tuser))
        else $error("tick result flagged rejected");

    // the input register never drops an item while the result side is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)
        && $stable(in_type_reg)))
        else $error("pending input lost");

endmodule

### bench/calendar_tick_counter_tb.sv
// self-checking bench for calendar_tick_counter: ticks and loads in both decode modes
// depends on ctc_pkg and the calendar_tick_counter rtl; results checked against a local calendar
`timescale 1ns / 1ps

module calendar_tick_counter_tb;

    import ctc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENT_ITEMS  = 200;

    typedef struct packed {
        logic        kind;
        logic [47:0] raw;  // year, month, day, hour, min, sec from the top byte down
    } clock_req_t;

    typedef struct packed {
        cal_time_t t;
        logic      rejected;
    } cal_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [LOAD_W-1:0]  s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [39:0]        m_axis_tdata;
    logic               m_axis_tuser;

    clock_req_t  req_q[$];
    cal_result_t result_q[$];

    int  cal_s, cal_mi, cal_h, cal_d, cal_mo, cal_y;
    bit  mode_bin;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  popped_cnt;
    int  accepted_cnt;
    int  result_cnt;
    int  mismatch_cnt;
    int  quiet_cycles;
    logic in_accepted;

    calendar_tick_counter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int month_length(int m, int y);
        if (m == 2)
            return (y % 4 == 0) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int decode_field(logic [7:0] b);
        if (mode_bin)
            return int'(b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] encode_field(int v);
        if (mode_bin)
            return 8'(v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // advance the local calendar by one request and return the time it shows after
    function automatic cal_result_t step_calendar(clock_req_t rq);
        cal_result_t r;
        int s, mi, h, d, mo, y;
        r.rejected = 1'b0;
        if (rq.kind == REQ_TICK)
        begin
            cal_s++;
            if (cal_s == 60)
            begin
                cal_s = 0;
                cal_mi++;
            end
            if (cal_mi == 60)
            begin
                cal_mi = 0;
                cal_h++;
            end
            if (cal_h == 24)
            begin
                cal_h = 0;
                cal_d++;
            end
            if (cal_d > month_length(cal_mo, cal_y))
            begin
                cal_d = 1;
                cal_mo++;
            end
            if (cal_mo == 13)
            begin
                cal_mo = 1;
                cal_y++;
            end
            if (cal_y == 100)
                cal_y = 0;
        end
        else
        begin
            s  = decode_field(rq.raw[7:0]);
            mi = decode_field(rq.raw[15:8]);
            h  = decode_field(rq.raw[23:16]);
            d  = decode_field(rq.raw[31:24]);
            mo = decode_field(rq.raw[39:32]);
            y  = decode_field(rq.raw[47:40]);
            if (s <= 59 && mi <= 59 && h <= 23 && y <= 99 && mo >= 1 && mo <= 12
                && d >= 1 && d <= month_length(mo, y))
            begin
                cal_s  = s;
                cal_mi = mi;
                cal_h  = h;
                cal_d  = d;
                cal_mo = mo;
                cal_y  = y;
            end
            else
                r.rejected = 1'b1;
        end
        r.t.sec   = 6'(cal_s);
        r.t.min   = 6'(cal_mi);
        r.t.hour  = 5'(cal_h);
        r.t.day   = 5'(cal_d);
        r.t.month = 4'(cal_mo);
        r.t.year  = 7'(cal_y);
        return r;
    endfunction

    task automatic queue_raw(logic kind, logic [47:0] raw);
        clock_req_t rq;
        rq.kind = kind;
        rq.raw  = raw;
        req_q.push_back(rq);
    endtask

    task automatic queue_tick();
        queue_raw(REQ_TICK, 48'({$urandom, $urandom}));
    endtask

    task automatic queue_load(int s, int mi, int h, int d, int mo, int y);
        queue_raw(REQ_LOAD, {encode_field(y), encode_field(mo), encode_field(d),
                             encode_field(h), encode_field(mi), encode_field(s)});
    endtask

    // mostly ticks and loads near rollover points, some broken loads and raw noise
    task automatic queue_random_item();
        int r, s, mi, h, d, mo, y, hi;
        r  = $urandom_range(99);
        hi = mode_bin ? 255 : 159;
        mo = $urandom_range(1, 12);
        case ($urandom_range(3))
            0:       y = 99;
            1:       y = 4 * $urandom_range(24);
            default: y = $urandom_range(99);
        endcase
        s  = $urandom_range(1) ? 59 : $urandom_range(59);
        mi = $urandom_range(1) ? 59 : $urandom_range(59);
        h  = $urandom_range(1) ? 23 : $urandom_range(23);
        d  = $urandom_range(1) ? month_length(mo, y) : $urandom_range(1, month_length(mo, y));
        if (r < 40)
            queue_tick();
        else if (r < 65)
            queue_load(59, 59, 23, d, mo, y);
        else if (r < 78)
            queue_load(s, mi, h, d, mo, y);
        else if (r < 92)
        begin
            case ($urandom_range(5))
                0: s  = $urandom_range(60, hi);
                1: mi = $urandom_range(60, hi);
                2: h  = $urandom_range(24, hi);
                3: d  = $urandom_range(1) ? 0 : $urandom_range(month_length(mo, y) + 1, hi);
                4: mo = $urandom_range(1) ? 0 : $urandom_range(13, hi);
                default: y = $urandom_range(100, hi);
            endcase
            queue_load(s, mi, h, d, mo, y);
        end
        else
            queue_raw(1'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic write_mode(bit m);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_bin     = m;
    endtask

    // sender holds off until the queue is empty and every result is back
    task automatic drain();
        while (req_q.size() != 0 || popped_cnt != accepted_cnt || result_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    always @(negedge clk)
    begin : driver
        clock_req_t rq;
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_accepted)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    rq = req_q.pop_front();
                    popped_cnt++;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rq.raw;
                    s_axis_tuser  <= rq.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        cal_result_t exp_r;
        cal_result_t act_r;
        logic        xfer;
        xfer = 1'b0;
        in_accepted <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                xfer = 1'b1;
                accepted_cnt++;
                result_q.push_back(step_calendar({s_axis_tuser, s_axis_tdata}));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                xfer = 1'b1;
                result_cnt++;
                act_r.t        = m_axis_tdata[32:0];
                act_r.rejected = m_axis_tuser;
                if (result_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d: expected none, got %0d:%0d:%0d %0d/%0d/%0d rej %0b",
                                 result_cnt, act_r.t.hour, act_r.t.min, act_r.t.sec,
                                 act_r.t.day, act_r.t.month, act_r.t.year, act_r.rejected);
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (act_r.t.sec != exp_r.t.sec || act_r.t.min != exp_r.t.min
                        || act_r.t.hour != exp_r.t.hour || act_r.t.day != exp_r.t.day
                        || act_r.t.month != exp_r.t.month || act_r.t.year != exp_r.t.year
                        || act_r.rejected != exp_r.rejected || m_axis_tdata[39:33] != 7'd0)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("result %0d: expected %0d:%0d:%0d %0d/%0d/%0d rej %0b",
                                     result_cnt, exp_r.t.hour, exp_r.t.min, exp_r.t.sec,
                                     exp_r.t.day, exp_r.t.month, exp_r.t.year, exp_r.rejected);
                            $display("result %0d: got %0d:%0d:%0d %0d/%0d/%0d rej %0b pad %0h",
                                     result_cnt, act_r.t.hour, act_r.t.min, act_r.t.sec,
                                     act_r.t.day, act_r.t.month, act_r.t.year, act_r.rejected,
                                     m_axis_tdata[39:33]);
                        end
                    end
                end
            end
            if (xfer)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("calendar_tick_counter_tb failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        bit seg_mode[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        in_accepted   = 1'b0;
        mode_bin      = 1'b0;
        tx_idle_pct   = 27;
        rx_idle_pct   = 76;
        popped_cnt    = 0;
        accepted_cnt  = 0;
        result_cnt    = 0;
        mismatch_cnt  = 0;
        quiet_cycles  = 0;
        cal_s  = 0;
        cal_mi = 0;
        cal_h  = 0;
        cal_d  = 1;
        cal_mo = 1;
        cal_y  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mode(1'b0);
        queue_tick();
        queue_load(59, 59, 23, 31, 12, 99);
        queue_tick();
        queue_load(59, 59, 23, 28, 2, 1);
        queue_tick();
        queue_load(59, 59, 23, 28, 2, 4);
        queue_tick();
        queue_load(59, 59, 23, 29, 2, 0);
        queue_tick();
        queue_load(59, 59, 23, 30, 4, 23);
        queue_tick();
        queue_load(0, 0, 0, 29, 2, 1);
        queue_load(0, 0, 0, 31, 4, 5);
        queue_load(0, 0, 0, 0, 1, 0);
        queue_load(0, 0, 0, 1, 0, 0);
        queue_load(0, 0, 0, 1, 13, 0);
        queue_load(60, 0, 0, 1, 1, 0);
        queue_load(0, 0, 24, 1, 1, 0);
        queue_load(0, 0, 0, 1, 1, 100);
        // minutes nibble above nine decodes to ten
        queue_raw(REQ_LOAD, {8'h00, 8'h01, 8'h01, 8'h12, 8'h0A, 8'h05});
        queue_raw(REQ_LOAD, '1);
        queue_raw(REQ_LOAD, '0);
        drain();

        for (int k = 0; k < 6; k++)
        begin
            if (k < 2)
            begin
                tx_idle_pct = 27;
                rx_idle_pct = 76;
            end
            else if (k < 4)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 27;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_mode(seg_mode[k]);
            if (k == 1)
            begin
                queue_load(59, 59, 23, 31, 12, 99);
                queue_tick();
                queue_load(89, 0, 0, 1, 1, 0);
                queue_load(0, 0, 0, 1, 1, 255);
            end
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                queue_random_item();
            drain();
        end

        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && result_q.size() == 0)
            $display("calendar_tick_counter_tb passed");
        else
            $display("calendar_tick_counter_tb failed");
        $finish;
    end

endmodule

### files.f
rtl/ctc_pkg.sv
rtl/ctc_next_time.sv
rtl/calendar_tick_counter.sv
bench/calendar_tick_counter_tb.sv
